### hw/rtl/cubic_bezier_time_evaluator_defines.svh
// ----------------------------------------------------------------------------
// cubic bezier time evaluator assertion macros
// shared property forms used by the checker
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_TIME_EVALUATOR_DEFINES_SVH
`define CUBIC_BEZIER_TIME_EVALUATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CBT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CBT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// shared types, constants and width helpers for the bezier time evaluator
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int COMPONENTS_DEF    = 4;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COMP_W     = 16;
    localparam int TIME_W     = 32;
    localparam int POINT_W    = 64;
    localparam int NUM_POINTS = 4;
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_POINT_START  = 3'd0;
    localparam cfg_index_t REG_POINT_CTRL_A = 3'd1;
    localparam cfg_index_t REG_POINT_CTRL_B = 3'd2;
    localparam cfg_index_t REG_POINT_END    = 3'd3;
    localparam cfg_index_t REG_TOTAL_TIME   = 3'd4;

    // multiplier sequence: two squares and four weight products, then the component products
    typedef logic [4:0] step_t;

    localparam step_t STEP_U2  = 5'd0;
    localparam step_t STEP_T2  = 5'd1;
    localparam step_t STEP_W0  = 5'd2;
    localparam step_t STEP_W1  = 5'd3;
    localparam step_t STEP_W2  = 5'd4;
    localparam step_t STEP_W3  = 5'd5;
    localparam step_t STEP_MAC = 5'd6;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    // signed operand widths of the shared multiplier
    function automatic int mul_a_w(input int frac_bits);
        int w;
        begin
            w = (frac_bits + 2 > COMP_W) ? frac_bits + 2 : COMP_W;
            return w + 1;
        end
    endfunction

    function automatic int mul_b_w(input int frac_bits);
        begin
            return frac_bits + 2;
        end
    endfunction

endpackage

### hw/rtl/cbt_div.sv
// ----------------------------------------------------------------------------
// cbt_div
// restoring divider, one quotient bit per cycle, gives elapsed/total as a
// fraction; saturates to one when elapsed reaches total or total is zero
// ----------------------------------------------------------------------------
module cbt_div
    import cbt_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [TIME_W-1:0]        dividend,
    input  logic [TIME_W-1:0]        divisor,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quot
);

    localparam int CW = $clog2(FRACTION_BITS + 1);
    localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [TIME_W-1:0]      rem_reg;
    logic [FRACTION_BITS:0] quot_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [TIME_W:0]        rem_dbl;
    logic [TIME_W:0]        rem_sub;
    logic                   fit;
    logic                   special;

    always_comb
    begin
        rem_dbl = {rem_reg, 1'b0};
        rem_sub = rem_dbl - {1'b0, divisor};
        fit     = rem_dbl >= {1'b0, divisor};
        special = (divisor == '0) || (dividend >= divisor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (special)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(FRACTION_BITS);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            quot_reg <= special ? ONE : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fit ? rem_sub[TIME_W-1:0] : rem_dbl[TIME_W-1:0];
            quot_reg <= {quot_reg[FRACTION_BITS-1:0], fit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### hw/rtl/cbt_mul.sv
// ----------------------------------------------------------------------------
// cbt_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module cbt_mul
    import cbt_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                                                          clk,
    input  logic                                                          en,
    input  logic signed [mul_a_w(FRACTION_BITS)-1:0]                      a,
    input  logic signed [mul_b_w(FRACTION_BITS)-1:0]                      b,
    output logic signed [mul_a_w(FRACTION_BITS)+mul_b_w(FRACTION_BITS)-1:0] prod
);

    localparam int PW = mul_a_w(FRACTION_BITS) + mul_b_w(FRACTION_BITS);

    logic signed [PW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/cubic_bezier_time_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_time_evaluator: bit-serial divider, one multiplier; the bit-serial divide is skipped
// when elapsed reaches total
// one item at a time; the input is free again once the result is in the output register
// async reset: elapsed time 0, total time 65536, control points 0, output empty
// ----------------------------------------------------------------------------
module cubic_bezier_time_evaluator
    import cbt_pkg::*;
#(
    parameter int COMPONENTS    = COMPONENTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic [TIME_W-1:0]        delta_time,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [COMP_W-1:0] comp_x,
    output logic signed [COMP_W-1:0] comp_y,
    output logic signed [COMP_W-1:0] comp_z,
    output logic signed [COMP_W-1:0] comp_w,
    output logic                     at_end,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [POINT_W-1:0]       cfg_data
);

    localparam int F     = FRACTION_BITS;
    localparam int WW    = F + 1;
    localparam int AW    = mul_a_w(F);
    localparam int BW    = mul_b_w(F);
    localparam int PW    = AW + BW;
    localparam int ACW   = COMP_W + F + 3;
    localparam int NSTEP = 6 + 4 * COMPONENTS;

    localparam step_t               STEP_END  = step_t'(NSTEP);
    localparam step_t               STEP_LAST = step_t'(NSTEP - 1);
    localparam logic [WW-1:0]       ONE       = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0]       HALF_P    = PW'(1) << (F - 1);
    localparam logic signed [ACW-1:0] HALF_A  = ACW'(1) << (F - 1);
    localparam logic signed [ACW-1:0] SAT_MAX = ACW'(32767);
    localparam logic signed [ACW-1:0] SAT_MIN = -ACW'(32768);

    state_t                   state_reg;
    state_t                   state_next;

    logic [POINT_W-1:0]       point_reg [NUM_POINTS];
    logic [TIME_W-1:0]        total_reg;
    logic [TIME_W-1:0]        elapsed_reg;
    logic                     end_reg;

    logic [WW-1:0]            t_reg;
    logic [WW-1:0]            u_reg;
    logic [WW-1:0]            u2_reg;
    logic [WW-1:0]            t2_reg;
    logic [WW-1:0]            w_reg [NUM_POINTS];

    step_t                    step_reg;
    step_t                    wb_step_reg;
    logic                     wb_pend_reg;
    logic signed [ACW-1:0]    acc_reg;
    logic signed [COMP_W-1:0] comp_reg [NUM_POINTS];

    logic                     out_valid_reg;
    logic signed [COMP_W-1:0] out_comp_reg [NUM_POINTS];
    logic                     out_end_reg;

    logic                     in_acc;
    logic [TIME_W:0]          sum_ext;
    logic                     fits;
    logic [TIME_W-1:0]        elapsed_new;
    logic                     div_done;
    logic [WW-1:0]            div_quot;

    logic                     issue;
    logic                     load;
    step_t                    mstep_i;
    step_t                    mstep_w;
    logic [1:0]               k_i;
    logic [1:0]               c_i;
    logic [1:0]               k_w;
    logic [1:0]               c_w;
    logic [POINT_W-1:0]       pt_sel;
    logic signed [COMP_W-1:0] pcomp;
    logic [AW-1:0]            a_raw;
    logic [BW-1:0]            b_raw;
    logic signed [PW-1:0]     prod;
    logic [PW-1:0]            rsum;
    logic [WW-1:0]            wval;
    logic signed [ACW-1:0]    prod_ext;
    logic signed [ACW-1:0]    acc_sum;
    logic signed [ACW-1:0]    acc_rnd;
    logic signed [ACW-1:0]    acc_shr;
    logic signed [COMP_W-1:0] comp_sat;

    // time update
    always_comb
    begin
        in_acc      = in_valid && !in_stall;
        sum_ext     = {1'b0, elapsed_reg} + {1'b0, delta_time};
        fits        = sum_ext <= {1'b0, total_reg};
        elapsed_new = action ? '0 : (fits ? sum_ext[TIME_W-1:0] : elapsed_reg);
    end

    cbt_div
    #(
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .dividend (elapsed_new),
        .divisor  (total_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                issue = step_reg != STEP_END;
                if (wb_pend_reg && (wb_step_reg == STEP_LAST))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                load = !out_valid_reg || !out_stall;
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_U2;
            wb_pend_reg <= 1'b0;
        end
        else
        begin
            wb_pend_reg <= issue;
            if ((state_reg == ST_DIV) && div_done)
            begin
                step_reg <= STEP_U2;
            end
            else if (issue)
            begin
                step_reg <= step_reg + step_t'(1);
            end
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mstep_i = step_reg - STEP_MAC;
        k_i     = mstep_i[1:0];
        c_i     = mstep_i[3:2];
        pt_sel  = point_reg[k_i];
        pcomp   = $signed(pt_sel[{c_i, 4'b0000} +: COMP_W]);
        case (step_reg)
            STEP_U2:
            begin
                a_raw = AW'(u_reg);
                b_raw = BW'(u_reg);
            end
            STEP_T2:
            begin
                a_raw = AW'(t_reg);
                b_raw = BW'(t_reg);
            end
            STEP_W0:
            begin
                a_raw = AW'(u2_reg);
                b_raw = BW'(u_reg);
            end
            STEP_W1:
            begin
                a_raw = AW'(u2_reg) + (AW'(u2_reg) << 1);
                b_raw = BW'(t_reg);
            end
            STEP_W2:
            begin
                a_raw = AW'(u_reg) + (AW'(u_reg) << 1);
                b_raw = BW'(t2_reg);
            end
            STEP_W3:
            begin
                a_raw = AW'(t2_reg);
                b_raw = BW'(t_reg);
            end
            default:
            begin
                a_raw = AW'(pcomp);
                b_raw = BW'(w_reg[k_i]);
            end
        endcase
    end

    cbt_mul
    #(
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_mul
    (
        .clk  (clk),
        .en   (issue),
        .a    ($signed(a_raw)),
        .b    ($signed(b_raw)),
        .prod (prod)
    );

    // product write-back: rounding of weights, accumulation and saturation
    always_comb
    begin
        mstep_w  = wb_step_reg - STEP_MAC;
        k_w      = mstep_w[1:0];
        c_w      = mstep_w[3:2];
        rsum     = prod + HALF_P;
        wval     = rsum[F +: WW];
        prod_ext = ACW'(prod);
        acc_sum  = ((k_w == 2'd0) ? '0 : acc_reg) + prod_ext;
        acc_rnd  = acc_sum + HALF_A;
        acc_shr  = acc_rnd >>> F;
        if (acc_shr > SAT_MAX)
        begin
            comp_sat = 16'sh7FFF;
        end
        else if (acc_shr < SAT_MIN)
        begin
            comp_sat = 16'sh8000;
        end
        else
        begin
            comp_sat = COMP_W'(acc_shr);
        end
    end

    always_ff @(posedge clk)
    begin
        wb_step_reg <= step_reg;
        if (in_acc)
        begin
            end_reg <= !action && !fits;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            t_reg <= div_quot;
            u_reg <= ONE - div_quot;
        end
        if (wb_pend_reg)
        begin
            case (wb_step_reg)
                STEP_U2: u2_reg   <= wval;
                STEP_T2: t2_reg   <= wval;
                STEP_W0: w_reg[0] <= wval;
                STEP_W1: w_reg[1] <= wval;
                STEP_W2: w_reg[2] <= wval;
                STEP_W3: w_reg[3] <= wval;
                default:
                begin
                    acc_reg <= acc_sum;
                    if (k_w == 2'd3)
                    begin
                        comp_reg[c_w] <= comp_sat;
                    end
                end
            endcase
        end
        if (load)
        begin
            out_end_reg <= end_reg;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                out_comp_reg[i] <= (i < COMPONENTS) ? comp_reg[i] : '0;
            end
        end
    end

    // elapsed time and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            total_reg   <= TIME_W'(65536);
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_acc)
            begin
                elapsed_reg <= elapsed_new;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POINT_START:  point_reg[0] <= cfg_data;
                    REG_POINT_CTRL_A: point_reg[1] <= cfg_data;
                    REG_POINT_CTRL_B: point_reg[2] <= cfg_data;
                    REG_POINT_END:    point_reg[3] <= cfg_data;
                    REG_TOTAL_TIME:   total_reg    <= cfg_data[TIME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= (out_valid_reg && out_stall) || load;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign comp_x    = out_comp_reg[0];
    assign comp_y    = out_comp_reg[1];
    assign comp_z    = out_comp_reg[2];
    assign comp_w    = out_comp_reg[3];
    assign at_end    = out_end_reg;

endmodule

### hw/rtl/cbt_checker.sv
// ----------------------------------------------------------------------------
// cbt_checker
// port-level checks of the bezier time evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "cubic_bezier_time_evaluator_defines.svh"

module cbt_checker
    import cbt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [COMP_W-1:0] comp_x,
    input logic signed [COMP_W-1:0] comp_y,
    input logic signed [COMP_W-1:0] comp_z,
    input logic signed [COMP_W-1:0] comp_w,
    input logic                     at_end
);

    logic [4*COMP_W:0] out_item;
    logic              out_held;
    logic              in_acc;

    assign out_item = {at_end, comp_w, comp_z, comp_y, comp_x};
    assign out_held = out_valid && out_stall;
    assign in_acc   = in_valid && !in_stall;

    // a held result keeps its item
    `CBT_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_item), "held item changed")

    // one item at a time
    `CBT_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall, "no stall after accept")

    // a new result frees the input side
    `CBT_ASSERT_IMP(a_result_frees_input, $rose(out_valid), !in_stall, "result while busy")

endmodule

bind cubic_bezier_time_evaluator cbt_checker u_cbt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .comp_x    (comp_x),
    .comp_y    (comp_y),
    .comp_z    (comp_z),
    .comp_w    (comp_w),
    .at_end    (at_end)
);

### tb/cubic_bezier_time_evaluator_checker.sv
// ----------------------------------------------------------------------------
// cubic_bezier_time_evaluator_checker
// follows register writes and accepted items, keeps its own elapsed time and
// curve setup, predicts each curve point and compares it field by field with
// every result the block hands out
// ----------------------------------------------------------------------------
module cubic_bezier_time_evaluator_checker
    import cbt_pkg::*;
#(
    parameter int COMPONENTS    = COMPONENTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     action,
    input  logic [TIME_W-1:0]        delta_time,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [COMP_W-1:0] comp_x,
    input  logic signed [COMP_W-1:0] comp_y,
    input  logic signed [COMP_W-1:0] comp_z,
    input  logic signed [COMP_W-1:0] comp_w,
    input  logic                     at_end,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [POINT_W-1:0]       cfg_data,
    output int                       mismatches,
    output int                       pending,
    output int                       refusals
);

    localparam logic [63:0]        FX_ONE  = 64'd1 << FRACTION_BITS;
    localparam logic [63:0]        FX_HALF = 64'd1 << (FRACTION_BITS - 1);
    localparam logic signed [63:0] ACC_HALF = 64'sd1 <<< (FRACTION_BITS - 1);

    typedef struct packed
    {
        logic [3:0][COMP_W-1:0] comp;
        logic                   at_end;
    } curve_point_t;

    logic [POINT_W-1:0] ctrl_pts [NUM_POINTS];
    logic [TIME_W-1:0]  span_ticks;
    logic [TIME_W-1:0]  elapsed_ticks;
    curve_point_t       expected_points [$];
    int                 fail_count = 0;
    int                 refuse_count = 0;

    function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + FX_HALF) >> FRACTION_BITS;
    endfunction

    function automatic curve_point_t curve_at(input logic [TIME_W-1:0] el,
                                              input logic [TIME_W-1:0] span);
        logic [63:0]        t;
        logic [63:0]        u;
        logic [63:0]        u2;
        logic [63:0]        t2;
        logic [63:0]        wt [4];
        logic signed [63:0] acc;
        logic signed [63:0] pv;
        logic signed [63:0] wv;
        logic signed [63:0] r;
        curve_point_t       p;
        p = '0;
        if (span == '0 || el >= span)
            t = FX_ONE;
        else
            t = ({32'd0, el} << FRACTION_BITS) / {32'd0, span};
        u  = FX_ONE - t;
        u2 = frac_mul(u, u);
        t2 = frac_mul(t, t);
        wt[0] = frac_mul(u2, u);
        wt[1] = frac_mul(3 * u2, t);
        wt[2] = frac_mul(3 * u, t2);
        wt[3] = frac_mul(t2, t);
        for (int c = 0; c < 4; c++)
        begin
            acc = '0;
            for (int k = 0; k < NUM_POINTS; k++)
            begin
                pv  = $signed(ctrl_pts[k][COMP_W*c +: COMP_W]);
                wv  = $signed(wt[k]);
                acc = acc + pv * wv;
            end
            r = (acc + ACC_HALF) >>> FRACTION_BITS;
            if (r > 64'sd32767)
                r = 64'sd32767;
            if (r < -64'sd32768)
                r = -64'sd32768;
            p.comp[c] = (c < COMPONENTS) ? r[COMP_W-1:0] : '0;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t    seen;
        curve_point_t    want;
        logic [TIME_W:0] reach;
        logic            refused;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_POINTS; k++)
                ctrl_pts[k] = '0;
            span_ticks    = 32'd65536;
            elapsed_ticks = '0;
            expected_points.delete();
            pending    <= 0;
            mismatches <= 0;
            refusals   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TOTAL_TIME)
                    span_ticks = cfg_data[TIME_W-1:0];
                else if (cfg_index < NUM_POINTS)
                    ctrl_pts[cfg_index[1:0]] = cfg_data;
            end

            if (out_valid && !out_stall)
            begin
                seen.comp   = {comp_w, comp_z, comp_y, comp_x};
                seen.at_end = at_end;
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected curve point: x %0d y %0d z %0d w %0d end %0b",
                                 comp_x, comp_y, comp_z, comp_w, at_end);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("curve point mismatch: want x %0d y %0d z %0d w %0d end %0b",
                                     $signed(want.comp[0]), $signed(want.comp[1]),
                                     $signed(want.comp[2]), $signed(want.comp[3]),
                                     want.at_end);
                            $display("                      got  x %0d y %0d z %0d w %0d end %0b",
                                     comp_x, comp_y, comp_z, comp_w, at_end);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                refused = 1'b0;
                if (action)
                    elapsed_ticks = '0;
                else
                begin
                    reach = {1'b0, elapsed_ticks} + {1'b0, delta_time};
                    if (reach <= {1'b0, span_ticks})
                        elapsed_ticks = reach[TIME_W-1:0];
                    else
                        refused = 1'b1;
                end
                want = curve_at(elapsed_ticks, span_ticks);
                want.at_end = refused;
                if (refused)
                    refuse_count++;
                expected_points.push_back(want);
            end

            pending    <= expected_points.size();
            mismatches <= fail_count;
            refusals   <= refuse_count;
        end
    end

endmodule

### tb/cubic_bezier_time_evaluator_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_time_evaluator_tb
// drives timing items and curve setups into the evaluator: a directed pass
// over the time and point extremes, then random phases with random gaps on
// both sides, a long output hold and full drains between setups
// ----------------------------------------------------------------------------
module cubic_bezier_time_evaluator_tb;
    import cbt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE        = 60;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 225;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic                     action     = 1'b0;
    logic [TIME_W-1:0]        delta_time = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
    logic signed [COMP_W-1:0] comp_w;
    logic                     at_end;
    logic                     cfg_valid  = 1'b0;
    logic                     cfg_ready;
    cfg_index_t               cfg_index  = REG_POINT_START;
    logic [POINT_W-1:0]       cfg_data   = '0;

    int                       mismatches;
    int                       pending;
    int                       refusals;
    int                       cycle_count = 0;
    int                       items_sent  = 0;
    int                       setups      = 0;
    logic [TIME_W-1:0]        span_now    = 32'd65536;
    logic                     tx_quiet    = 1'b0;
    logic                     rx_quiet    = 1'b0;
    logic                     hold_request = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cubic_bezier_time_evaluator dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .delta_time (delta_time),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .comp_x     (comp_x),
        .comp_y     (comp_y),
        .comp_z     (comp_z),
        .comp_w     (comp_w),
        .at_end     (at_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    cubic_bezier_time_evaluator_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .delta_time (delta_time),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .comp_x     (comp_x),
        .comp_y     (comp_y),
        .comp_z     (comp_z),
        .comp_w     (comp_w),
        .at_end     (at_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .refusals   (refusals)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("cubic_bezier_time_evaluator_tb: errors");
            $finish;
        end
    end

    // output side: random hold-off per result, one long hold on request
    initial
    begin : result_sink
        int   n;
        logic hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            n = rx_quiet ? 0 : $urandom_range(0, 12);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic send_item(input logic act, input logic [TIME_W-1:0] dt);
        int n;
        n = tx_quiet ? 0 : $urandom_range(0, 12);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        delta_time <= dt;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [POINT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_span(input logic [TIME_W-1:0] span);
        write_reg(REG_TOTAL_TIME, {$urandom, span});
        span_now = span;
    endtask

    task automatic load_curve(input logic [POINT_W-1:0] p0, input logic [POINT_W-1:0] p1,
                              input logic [POINT_W-1:0] p2, input logic [POINT_W-1:0] p3,
                              input logic [TIME_W-1:0] span);
        write_reg(REG_POINT_START, p0);
        write_reg(REG_POINT_CTRL_A, p1);
        write_reg(REG_POINT_CTRL_B, p2);
        write_reg(REG_POINT_END, p3);
        write_span(span);
        // indexes past the last register must leave the setup alone
        if ($urandom_range(0, 1) == 0)
            write_reg(cfg_index_t'(REG_TOTAL_TIME + $urandom_range(1, 3)), {$urandom, $urandom});
        setups++;
    endtask

    function automatic logic [POINT_W-1:0] random_point();
        logic [POINT_W-1:0] p;
        for (int c = 0; c < 4; c++)
        begin
            case ($urandom_range(0, 5))
                0:       p[COMP_W*c +: COMP_W] = 16'h7FFF;
                1:       p[COMP_W*c +: COMP_W] = 16'h8000;
                2:       p[COMP_W*c +: COMP_W] = 16'h0000;
                default: p[COMP_W*c +: COMP_W] = $urandom;
            endcase
        end
        return p;
    endfunction

    function automatic logic [TIME_W-1:0] random_span();
        case ($urandom_range(0, 7))
            0:       return 32'd1;
            1:       return $urandom_range(2, 40);
            2:       return 32'd1 << $urandom_range(4, 31);
            3:       return 32'hFFFF_FFFF;
            4:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] random_delta(input logic [TIME_W-1:0] span);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom_range(1, 3);
            2, 3, 4: return span >> $urandom_range(0, 12);
            5:       return $urandom;
            6:       return 32'hFFFF_FFFF;
            default: return span >> $urandom_range(1, 6);
        endcase
    endfunction

    initial
    begin : stimulus
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // setup straight out of reset
        send_item(1'b0, 32'd0);
        send_item(1'b0, 32'd32768);
        drain();

        load_curve({4{16'h8000}}, {4{16'h7FFF}}, 64'h7FFF_0000_8000_FFFF, {4{16'h7FFF}},
                   32'd65536);
        send_item(1'b1, 32'hFFFF_FFFF);
        send_item(1'b0, 32'd1);
        send_item(1'b0, 32'd0);
        send_item(1'b0, 32'd65535);
        send_item(1'b0, 32'd1);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, 32'd0);
        drain();

        // all four points alike, with components at both rails
        load_curve({4{16'h7FFF}} & 64'h0000_1234_8000_7FFF | 64'h0000_1234_8000_7FFF,
                   64'h0000_1234_8000_7FFF, 64'h0000_1234_8000_7FFF, 64'h0000_1234_8000_7FFF,
                   32'd65536);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'd21845);
        send_item(1'b0, 32'd10000);
        drain();

        // total time lowered under the elapsed time
        write_span(32'd1000);
        send_item(1'b0, 32'd0);
        send_item(1'b1, 32'h5A5A_A5A5);
        drain();

        write_span(32'd0);
        send_item(1'b0, 32'd0);
        send_item(1'b0, 32'd1);
        drain();

        write_span(32'hFFFF_FFFF);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, 32'd1);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'h8000_0000);
        drain();

        write_span(32'd1);
        send_item(1'b1, 32'd7);
        send_item(1'b0, 32'd1);
        send_item(1'b0, 32'd1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            tx_quiet = (ph == 1 || ph == 2);
            rx_quiet = (ph == 1);
            load_curve(random_point(), random_point(), random_point(), random_point(),
                       random_span());
            if (ph == 2)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(0, 11) == 0)
                    send_item(1'b1, $urandom);
                else
                    send_item(1'b0, random_delta(span_now));
            end
            drain();
        end

        repeat (SETTLE) @(negedge clk);
        $display("run covered %0d items over %0d curve setups, %0d advances refused past the end",
                 items_sent, setups, refusals);
        if (mismatches == 0 && pending == 0)
            $display("cubic_bezier_time_evaluator_tb: clean");
        else
            $display("cubic_bezier_time_evaluator_tb: errors");
        $finish;
    end

endmodule
